// ===== rtl/core/kmd_pkg.sv =====
`default_nettype none
package kmd_pkg;

  localparam int ROWS_DEF = 8;
  localparam int COLS_DEF = 16;

  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_DEBOUNCING = 2'd1;
  localparam logic [1:0] PH_PRESSED    = 2'd2;
  localparam logic [1:0] PH_RELEASED   = 2'd3;

  localparam logic [1:0] MODE_TIMER   = 2'd0;
  localparam logic [1:0] MODE_COUNTER = 2'd1;
  localparam logic [1:0] MODE_FSM     = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] CFG_MODE      = 2'd0;
  localparam logic [1:0] CFG_SETTLE    = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [1:0]  MODE_RST      = MODE_TIMER;
  localparam logic [15:0] SETTLE_RST    = 16'd20;
  localparam logic [6:0]  THRESHOLD_RST = 7'd5;

  localparam logic signed [7:0] COUNT_MAX = 8'sd127;
  localparam logic signed [7:0] COUNT_MIN = -8'sd127;

  typedef struct packed {
    logic [3:0]  key_row;
    logic [4:0]  key_col;
    logic        raw_pressed;
    logic [31:0] sample_time;
  } sample_t;

  typedef struct packed {
    logic       change_event;
    logic [1:0] key_status;
  } result_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [31:0]       stamp;
    logic signed [7:0] count;
  } entry_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] settle;
    logic [6:0]  threshold;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/kmd_ram.sv =====
`default_nettype none
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/kmd_update.sv =====
`default_nettype none
module kmd_update (
  input  wire kmd_pkg::entry_t cur,
  input  wire logic            pressed,
  input  wire logic [31:0]     now,
  input  wire kmd_pkg::cfg_t   cfg,
  output kmd_pkg::entry_t      nxt,
  output logic                 ev,
  output logic                 we
);

  logic [31:0]       diff;
  logic              settled;
  logic signed [7:0] th_pos;
  logic signed [7:0] th_neg;
  logic signed [7:0] c_up;
  logic signed [7:0] c_dn;

  always_comb begin
    diff    = now - cur.stamp;
    settled = !diff[31] && (diff >= {16'd0, cfg.settle});
    th_pos  = signed'({1'b0, cfg.threshold});
    th_neg  = -th_pos;
    c_up    = (cur.count < kmd_pkg::COUNT_MAX) ? cur.count + 8'sd1 : cur.count;
    c_dn    = (cur.count > kmd_pkg::COUNT_MIN) ? cur.count - 8'sd1 : cur.count;
  end

  always_comb begin
    nxt = cur;
    ev  = 1'b0;
    we  = 1'b1;
    unique case (cfg.mode)
      kmd_pkg::MODE_TIMER: begin
        if (settled) begin
          nxt.stamp = now;
          if (pressed && cur.phase != kmd_pkg::PH_PRESSED) begin
            nxt.phase = kmd_pkg::PH_PRESSED;
            ev        = 1'b1;
          end else if (!pressed && cur.phase != kmd_pkg::PH_RELEASED) begin
            nxt.phase = kmd_pkg::PH_RELEASED;
            ev        = 1'b1;
          end
        end
      end
      kmd_pkg::MODE_COUNTER: begin
        if (pressed) begin
          nxt.count = c_up;
          if (c_up >= th_pos && cur.phase != kmd_pkg::PH_PRESSED) begin
            nxt.phase = kmd_pkg::PH_PRESSED;
            nxt.count = 8'sd0;
            ev        = 1'b1;
          end
        end else begin
          nxt.count = c_dn;
          if (c_dn <= th_neg && cur.phase != kmd_pkg::PH_RELEASED) begin
            nxt.phase = kmd_pkg::PH_RELEASED;
            nxt.count = 8'sd0;
            ev        = 1'b1;
          end
        end
      end
      kmd_pkg::MODE_FSM: begin
        case (cur.phase)
          kmd_pkg::PH_IDLE: begin
            if (pressed) begin
              nxt.phase = kmd_pkg::PH_DEBOUNCING;
              nxt.stamp = now;
            end
          end
          kmd_pkg::PH_DEBOUNCING: begin
            if (settled) begin
              nxt.phase = pressed ? kmd_pkg::PH_PRESSED : kmd_pkg::PH_IDLE;
              ev        = pressed;
            end
          end
          kmd_pkg::PH_PRESSED: begin
            if (!pressed) begin
              nxt.phase = kmd_pkg::PH_RELEASED;
              nxt.stamp = now;
            end
          end
          default: begin
            if (settled) begin
              nxt.phase = pressed ? kmd_pkg::PH_PRESSED : kmd_pkg::PH_IDLE;
              ev        = !pressed;
            end
          end
        endcase
      end
      kmd_pkg::MODE_NONE: begin
        we = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/key_matrix_debouncer_core.sv =====
// The update stage holds an accepted item and its store read, and registers the result and done.
// Throughput: one item per cycle while busy is low; the per-key store has one read and one
// write port, and an update to the same key in the previous cycle is forwarded around the
// memory. Reset: the store is swept to idle, time 0 and count 0, one key per cycle, with busy
// high; configuration writes are taken during the sweep. Results cannot be stalled.
`default_nettype none
module key_matrix_debouncer_core #(
  parameter int ROWS = kmd_pkg::ROWS_DEF,
  parameter int COLS = kmd_pkg::COLS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire kmd_pkg::sample_t sample,
  output logic                  done,
  output kmd_pkg::result_t      result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);

  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int EW    = $bits(kmd_pkg::entry_t);

  kmd_pkg::cfg_t    cfg;
  logic             clearing;
  logic [AW-1:0]    clr_addr;
  logic             accept;
  logic             in_range;
  logic [AW-1:0]    in_addr;
  logic             s1_valid;
  logic             s1_inrange;
  logic [AW-1:0]    s1_addr;
  kmd_pkg::sample_t s1_sample;
  logic [EW-1:0]    rdata;
  kmd_pkg::entry_t  cur;
  kmd_pkg::entry_t  nxt;
  logic             ev;
  logic             upd_we;
  logic             item_we;
  logic             wb_valid;
  logic [AW-1:0]    wb_addr;
  kmd_pkg::entry_t  wb_data;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [EW-1:0]    ram_wdata;

  assign busy      = clearing;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_range  = (int'(sample.key_row) < ROWS) && (int'(sample.key_col) < COLS);
  assign in_addr   = AW'(int'(sample.key_row) * COLS + int'(sample.key_col));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= kmd_pkg::MODE_RST;
      cfg.settle    <= kmd_pkg::SETTLE_RST;
      cfg.threshold <= kmd_pkg::THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kmd_pkg::CFG_MODE:      cfg.mode      <= cfg_data[1:0];
        kmd_pkg::CFG_SETTLE:    cfg.settle    <= cfg_data;
        kmd_pkg::CFG_THRESHOLD: cfg.threshold <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_inrange <= in_range;
      s1_addr    <= in_addr;
      s1_sample  <= sample;
    end
  end

  assign cur = (wb_valid && wb_addr == s1_addr) ? wb_data : kmd_pkg::entry_t'(rdata);

  kmd_update u_update (
    .cur     (cur),
    .pressed (s1_sample.raw_pressed),
    .now     (s1_sample.sample_time),
    .cfg     (cfg),
    .nxt     (nxt),
    .ev      (ev),
    .we      (upd_we)
  );

  assign item_we = s1_valid && s1_inrange && upd_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      wb_valid <= item_we;
      done     <= s1_valid;
    end
    wb_addr             <= s1_addr;
    wb_data             <= nxt;
    result.change_event <= s1_inrange && ev;
    result.key_status   <= s1_inrange ? nxt.phase : kmd_pkg::PH_IDLE;
  end

  assign ram_we    = clearing || item_we;
  assign ram_waddr = clearing ? clr_addr : s1_addr;
  assign ram_wdata = clearing ? '0 : EW'(nxt);

  kmd_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (rdata)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("Result strobe missing after an item in the update stage.");

  a_no_item_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !item_we)
    else $error("Item write-back during the clearing sweep.");

  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_inrange) |=>
      (done && !result.change_event && result.key_status == kmd_pkg::PH_IDLE))
    else $error("Out-of-range key did not report idle without an event.");

  a_sweep_complete: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == AW'(DEPTH - 1))
    else $error("Clearing sweep ended before the last entry.");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import kmd_pkg::*;

  localparam int KEY_ROWS = ROWS_DEF;
  localparam int KEY_COLS = COLS_DEF;
  localparam int NUM_KEYS = KEY_ROWS * KEY_COLS;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  sample_t sample = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_MODE;
  logic [15:0] cfg_data = '0;

  logic [1:0] key_state [NUM_KEYS];
  logic [31:0] change_stamp [NUM_KEYS];
  int vote_tally [NUM_KEYS];
  logic [1:0] mode_reg = MODE_RST;
  logic [15:0] settle_reg = SETTLE_RST;
  logic [6:0] threshold_reg = THRESHOLD_RST;

  result_t pending_results[$];
  int error_count = 0;
  int stall_cycles = 0;
  int gap_pct = 31;

  key_matrix_debouncer_core #(
    .ROWS(KEY_ROWS),
    .COLS(KEY_COLS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic result_t debounce_sample(sample_t s);
    int k;
    int diff;
    int th;
    int votes;
    logic [1:0] ph;
    logic [31:0] stamp;
    bit settled;
    bit pressed;
    result_t r;
    r = '0;
    r.key_status = PH_IDLE;
    if (s.key_row >= KEY_ROWS || s.key_col >= KEY_COLS) begin
      return r;
    end
    k = s.key_row * KEY_COLS + s.key_col;
    ph = key_state[k];
    stamp = change_stamp[k];
    votes = vote_tally[k];
    pressed = s.raw_pressed;
    diff = s.sample_time - stamp;
    settled = diff >= int'(settle_reg);
    th = int'(threshold_reg);
    case (mode_reg)
      MODE_TIMER: begin
        if (settled) begin
          stamp = s.sample_time;
          if (pressed && ph != PH_PRESSED) begin
            ph = PH_PRESSED;
            r.change_event = 1'b1;
          end else if (!pressed && ph != PH_RELEASED) begin
            ph = PH_RELEASED;
            r.change_event = 1'b1;
          end
        end
      end
      MODE_COUNTER: begin
        if (pressed) begin
          if (votes < 127) votes++;
          if (votes >= th && ph != PH_PRESSED) begin
            ph = PH_PRESSED;
            votes = 0;
            r.change_event = 1'b1;
          end
        end else begin
          if (votes > -127) votes--;
          if (votes <= -th && ph != PH_RELEASED) begin
            ph = PH_RELEASED;
            votes = 0;
            r.change_event = 1'b1;
          end
        end
      end
      MODE_FSM: begin
        case (ph)
          PH_IDLE: begin
            if (pressed) begin
              ph = PH_DEBOUNCING;
              stamp = s.sample_time;
            end
          end
          PH_DEBOUNCING: begin
            if (settled) begin
              ph = pressed ? PH_PRESSED : PH_IDLE;
              r.change_event = pressed;
            end
          end
          PH_PRESSED: begin
            if (!pressed) begin
              ph = PH_RELEASED;
              stamp = s.sample_time;
            end
          end
          default: begin
            if (settled) begin
              ph = pressed ? PH_PRESSED : PH_IDLE;
              r.change_event = !pressed;
            end
          end
        endcase
      end
      default: ;
    endcase
    key_state[k] = ph;
    change_stamp[k] = stamp;
    vote_tally[k] = votes;
    r.key_status = ph;
    return r;
  endfunction

  task automatic send_sample(input logic [3:0] row, input logic [4:0] col, input logic lvl,
                             input logic [31:0] stamp);
    sample_t s;
    s.key_row = row;
    s.key_col = col;
    s.raw_pressed = lvl;
    s.sample_time = stamp;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(debounce_sample(s));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MODE: mode_reg = data[1:0];
      CFG_SETTLE: settle_reg = data;
      CFG_THRESHOLD: threshold_reg = data[6:0];
      default: ;
    endcase
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] mode_data, input logic [15:0] settle_data,
                           input logic [15:0] threshold_data);
    drain_results();
    write_reg(CFG_MODE, mode_data, 1'b0);
    write_reg(CFG_SETTLE, settle_data, 1'b0);
    write_reg(CFG_THRESHOLD, threshold_data, 1'b1);
  endtask

  // Reset settings: timer lockout with a 20 unit interval.
  task automatic test_timer_defaults();
    send_sample(4'd0, 5'd0, 1'b1, 32'd0);
    send_sample(4'd0, 5'd0, 1'b1, 32'd20);
    send_sample(4'd0, 5'd0, 1'b0, 32'd25);
    send_sample(4'd0, 5'd0, 1'b0, 32'd45);
    send_sample(4'd7, 5'd15, 1'b1, 32'hFFFF_FFFF);
    send_sample(4'd7, 5'd15, 1'b1, 32'h7FFF_FFFF);
    send_sample(4'd7, 5'd15, 1'b0, 32'hFFFF_FFFF);
    send_sample(4'd0, 5'd16, 1'b0, 32'd0);
    send_sample(4'd15, 5'd31, 1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_register_extremes();
    configure({14'h0, MODE_TIMER}, 16'd0, 16'd5);
    send_sample(4'd3, 5'd3, 1'b1, 32'd0);
    configure({14'h3FFF, MODE_TIMER}, 16'hFFFF, 16'd5);
    send_sample(4'd3, 5'd3, 1'b0, 32'd65534);
    send_sample(4'd3, 5'd3, 1'b0, 32'd65535);
    configure(16'hFFFF, 16'd20, 16'd5);
    send_sample(4'd3, 5'd3, 1'b1, 32'd70000);
    drain_results();
    write_reg(CFG_SPARE, 16'hFFFF, 1'b1);
    send_sample(4'd9, 5'd20, 1'b1, 32'd70000);
  endtask

  // Threshold zero arrives with the unused upper data bits set.
  task automatic test_counter_threshold();
    configure({14'h0, MODE_COUNTER}, 16'd20, 16'hFF80);
    send_sample(4'd1, 5'd2, 1'b1, 32'd0);
    send_sample(4'd1, 5'd2, 1'b0, 32'd0);
    send_sample(4'd1, 5'd2, 1'b0, 32'd0);
    configure({14'h0, MODE_COUNTER}, 16'd20, 16'd2);
    send_sample(4'd1, 5'd2, 1'b1, 32'd0);
    send_sample(4'd1, 5'd2, 1'b1, 32'd0);
    send_sample(4'd1, 5'd2, 1'b1, 32'd0);
  endtask

  task automatic test_fsm_walk();
    configure({14'h0, MODE_FSM}, 16'd10, 16'd5);
    send_sample(4'd2, 5'd5, 1'b1, 32'd100);
    send_sample(4'd2, 5'd5, 1'b1, 32'd105);
    send_sample(4'd2, 5'd5, 1'b1, 32'd110);
    send_sample(4'd2, 5'd5, 1'b0, 32'd120);
    send_sample(4'd2, 5'd5, 1'b0, 32'd130);
    send_sample(4'd2, 5'd5, 1'b1, 32'd200);
    send_sample(4'd2, 5'd5, 1'b0, 32'd215);
    send_sample(4'd2, 5'd5, 1'b1, 32'd300);
    send_sample(4'd2, 5'd5, 1'b1, 32'd310);
    send_sample(4'd2, 5'd5, 1'b0, 32'd311);
    send_sample(4'd2, 5'd5, 1'b1, 32'd330);
  endtask

  // Drives one key to each vote limit, then a third to the largest threshold.
  task automatic test_counter_saturation();
    int i;
    gap_pct = 0;
    configure({14'h0, MODE_COUNTER}, 16'd20, 16'd1);
    send_sample(4'd4, 5'd7, 1'b1, 32'd0);
    send_sample(4'd5, 5'd9, 1'b0, 32'd0);
    configure({14'h0, MODE_COUNTER}, 16'd20, 16'd127);
    for (i = 0; i < 130; i++) begin
      send_sample(4'd4, 5'd7, 1'b1, $urandom);
      send_sample(4'd5, 5'd9, 1'b0, $urandom);
    end
    for (i = 0; i < 127; i++) begin
      send_sample(4'd6, 5'd1, 1'b1, $urandom);
    end
    gap_pct = 31;
  endtask

  // Modes change between rounds without clearing the store, so every mode
  // sees state codes left behind by the others.
  task automatic test_random_traffic(input int rounds, input int per_round);
    int p;
    int n;
    int sel;
    int span;
    int h;
    logic [3:0] row;
    logic [4:0] col;
    logic lvl;
    logic [31:0] now;
    logic [1:0] mode;
    logic [15:0] settle;
    logic [15:0] mode_data;
    logic [15:0] threshold_data;
    logic [3:0] hot_row [4];
    logic [4:0] hot_col [4];
    logic hot_level [4];
    for (p = 0; p < rounds; p++) begin
      mode = (p < 8) ? 2'(p % 4) : 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0: settle = 16'd0;
        1: settle = 16'hFFFF;
        2: settle = 16'd1;
        default: settle = 16'($urandom_range(2, 40));
      endcase
      threshold_data = 16'($urandom);
      case ($urandom_range(0, 5))
        0: threshold_data[6:0] = 7'd1;
        1: threshold_data[6:0] = 7'd127;
        2: threshold_data[6:0] = 7'd0;
        default: threshold_data[6:0] = 7'($urandom_range(2, 8));
      endcase
      mode_data = 16'($urandom);
      mode_data[1:0] = mode;
      configure(mode_data, settle, threshold_data);
      gap_pct = (p == 4) ? 0 : 31;
      for (h = 0; h < 4; h++) begin
        hot_row[h] = 4'($urandom_range(0, KEY_ROWS - 1));
        hot_col[h] = 5'($urandom_range(0, KEY_COLS - 1));
        hot_level[h] = 1'($urandom_range(0, 1));
      end
      case ($urandom_range(0, 2))
        0: now = $urandom;
        1: now = 32'hFFFF_FF00;
        default: now = '0;
      endcase
      span = int'(settle) + 4;
      for (n = 0; n < per_round; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          h = $urandom_range(0, 3);
          if ($urandom_range(0, 99) < 15) hot_level[h] = !hot_level[h];
          row = hot_row[h];
          col = hot_col[h];
          lvl = ($urandom_range(0, 99) < 80) ? hot_level[h] : 1'($urandom_range(0, 1));
        end else if (sel < 90) begin
          row = 4'($urandom_range(0, KEY_ROWS - 1));
          col = 5'($urandom_range(0, KEY_COLS - 1));
          lvl = 1'($urandom_range(0, 1));
        end else begin
          if ($urandom_range(0, 1)) begin
            row = 4'($urandom_range(KEY_ROWS, 15));
            col = 5'($urandom_range(0, 31));
          end else begin
            row = 4'($urandom_range(0, 15));
            col = 5'($urandom_range(KEY_COLS, 31));
          end
          lvl = 1'($urandom_range(0, 1));
        end
        sel = $urandom_range(0, 99);
        if (sel < 50) now = now + $urandom_range(0, span / 3);
        else if (sel < 92) now = now + $urandom_range(span / 2, 2 * span);
        else if (sel < 96) now = $urandom;
        else now = now - $urandom_range(1, span);
        send_sample(row, col, lvl, now);
      end
    end
    gap_pct = 31;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %p", $time, result);
      end else begin
        want = pending_results.pop_front();
        if (result.change_event !== want.change_event) begin
          error_count++;
          $display("%0t: change_event mismatch, expected %0b, actual %0b", $time,
                   want.change_event, result.change_event);
        end
        if (result.key_status !== want.key_status) begin
          error_count++;
          $display("%0t: key_status mismatch, expected %0d, actual %0d", $time,
                   want.key_status, result.key_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("key_matrix_debouncer_core regression: fail");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_state[k] = PH_IDLE;
      change_stamp[k] = '0;
      vote_tally[k] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_timer_defaults();
    test_register_extremes();
    test_counter_threshold();
    test_fsm_walk();
    test_counter_saturation();
    test_random_traffic(9, 105);
    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("key_matrix_debouncer_core regression: pass");
    end else begin
      $display("key_matrix_debouncer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/kmd_pkg.sv
rtl/core/kmd_ram.sv
rtl/core/kmd_update.sv
rtl/core/key_matrix_debouncer_core.sv
tb/testbench.sv
